/* rtl/core/hbs_pkg.sv */
// ----------------------------------------------------------------------------
// hbs_pkg
// Shared types, widths and constants of the heightmap box smoothing block.
// ----------------------------------------------------------------------------
package hbs_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 4096;

	localparam int PIXEL_W      = 8;
	localparam int SUM_W        = 12;
	localparam int SCALE_W      = 16;
	localparam int PROD_W       = 28;
	localparam int RECIP_W      = 32;
	localparam int QUOT_W       = PROD_W + RECIP_W;
	localparam int SHIFT_W      = 6;
	localparam int CNT_W        = 4;
	localparam int HEIGHT_W     = 24;
	localparam int ROW_FIELD_W  = 12;
	localparam int COL_FIELD_W  = 10;
	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 13;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

	localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 11'd256;
	localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 13'd256;
	localparam logic [SCALE_W-1:0]      HEIGHT_SCALE_RST = 16'd256;

	localparam int OUT_FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);

	typedef struct packed {
		logic left;
		logic right;
		logic top;
		logic bottom;
	} nbr_mask_t;

	typedef struct packed {
		logic                   emit;
		nbr_mask_t              mask;
		logic [ROW_FIELD_W-1:0] row;
		logic [COL_FIELD_W-1:0] col;
		logic                   last;
	} out_tag_t;

	typedef struct packed {
		logic [HEIGHT_W-1:0]    height;
		logic [ROW_FIELD_W-1:0] row;
		logic [COL_FIELD_W-1:0] col;
		logic                   last;
	} result_t;

	typedef struct packed {
		logic [RECIP_W-1:0] mult;
		logic [SHIFT_W-1:0] shift;
	} recip_t;

	// Reciprocal multiplier and shift for each neighbor count. The products
	// stay below 2^28, where these factors give the exact floor quotient.
	function automatic recip_t recip_for(input logic [CNT_W-1:0] count);
		recip_t r;
		case (count)
			4'd2: begin
				r.mult  = 32'd1;
				r.shift = 6'd1;
			end
			4'd3: begin
				r.mult  = 32'd357913942;
				r.shift = 6'd30;
			end
			4'd4: begin
				r.mult  = 32'd1;
				r.shift = 6'd2;
			end
			4'd6: begin
				r.mult  = 32'd357913942;
				r.shift = 6'd31;
			end
			4'd9: begin
				r.mult  = 32'd3817748708;
				r.shift = 6'd35;
			end
			default: begin
				r.mult  = 32'd1;
				r.shift = 6'd0;
			end
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/hbs_stream_if.sv */
// ----------------------------------------------------------------------------
// hbs_stream_if
// Valid/ready channels for incoming pixel words and outgoing result words.
// ----------------------------------------------------------------------------
interface hbs_pixel_if import hbs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               action;
	logic [PIXEL_W-1:0] pixel;

	modport source(output valid, output action, output pixel, input ready);
	modport sink(input valid, input action, input pixel, output ready);
endinterface

interface hbs_result_if import hbs_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [HEIGHT_W-1:0]    height;
	logic [ROW_FIELD_W-1:0] out_row;
	logic [COL_FIELD_W-1:0] out_col;
	logic                   frame_last;

	modport source(output valid, output height, output out_row, output out_col,
		output frame_last, input ready);
	modport sink(input valid, input height, input out_row, input out_col,
		input frame_last, output ready);
endinterface

/* rtl/core/hbs_window.sv */
// ----------------------------------------------------------------------------
// hbs_window
// Line store, 3x3 window and masked neighborhood sum.
// ----------------------------------------------------------------------------
module hbs_window import hbs_pkg::*; #(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       go,
	input  logic [$clog2(MAX_WIDTH)-1:0] col,
	input  logic [PIXEL_W-1:0]         pix,
	input  out_tag_t                   tag,
	output logic                       sum_valid,
	output logic [SUM_W-1:0]           sum,
	output logic [CNT_W-1:0]           count,
	output out_tag_t                   sum_tag
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	// Each entry holds the previous row in the high byte and the row before
	// it in the low byte.
	logic [2*PIXEL_W-1:0] line_mem [MAX_WIDTH];

	logic [2*PIXEL_W-1:0] rd_s1;
	logic [2*PIXEL_W-1:0] fwd_data_s1;
	logic                 fwd_s1;
	logic                 v_s1;
	logic [COL_W-1:0]     c_s1;
	logic [PIXEL_W-1:0]   pix_s1;
	out_tag_t             tag_s1;

	logic [PIXEL_W-1:0]   a_cur;
	logic [PIXEL_W-1:0]   b_cur;

	logic [PIXEL_W-1:0]   win_q [3][3];

	logic                 v_s2;
	out_tag_t             tag_s2;

	logic [SUM_W-1:0]     sum_c;
	logic [CNT_W-1:0]     count_c;

	logic                 v_s3;
	logic [SUM_W-1:0]     sum_s3;
	logic [CNT_W-1:0]     count_s3;
	out_tag_t             tag_s3;

	// When the same entry is read right behind its write, take the word
	// that the write puts there.
	assign a_cur = fwd_s1 ? fwd_data_s1[2*PIXEL_W-1:PIXEL_W] : rd_s1[2*PIXEL_W-1:PIXEL_W];
	assign b_cur = fwd_s1 ? fwd_data_s1[PIXEL_W-1:0] : rd_s1[PIXEL_W-1:0];

	always_ff @(posedge clk) begin
		if (go) begin
			rd_s1 <= line_mem[col];
		end
		if (v_s1) begin
			line_mem[c_s1] <= {pix_s1, a_cur};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			v_s1 <= go;
			if (go) begin
				fwd_s1 <= v_s1 && (c_s1 == col);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			c_s1        <= col;
			pix_s1      <= pix;
			tag_s1      <= tag;
			fwd_data_s1 <= {pix_s1, a_cur};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					win_q[i][j] <= '0;
				end
			end
		end else if (v_s1) begin
			for (int j = 0; j < 3; j++) begin
				win_q[0][j] <= win_q[1][j];
				win_q[1][j] <= win_q[2][j];
			end
			win_q[2][0] <= b_cur;
			win_q[2][1] <= a_cur;
			win_q[2][2] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s2 <= v_s1 && tag_s1.emit;
			v_s3 <= v_s2;
		end
	end

	always_comb begin
		logic [2:0] col_ok;
		logic [2:0] row_ok;
		logic [1:0] ncols;
		logic [1:0] nrows;
		col_ok = {tag_s2.mask.right, 1'b1, tag_s2.mask.left};
		row_ok = {tag_s2.mask.bottom, 1'b1, tag_s2.mask.top};
		sum_c  = '0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (col_ok[i] && row_ok[j]) begin
					sum_c = sum_c + SUM_W'(win_q[i][j]);
				end
			end
		end
		ncols   = 2'd1 + 2'(tag_s2.mask.left) + 2'(tag_s2.mask.right);
		nrows   = 2'd1 + 2'(tag_s2.mask.top) + 2'(tag_s2.mask.bottom);
		count_c = CNT_W'(ncols) * CNT_W'(nrows);
	end

	always_ff @(posedge clk) begin
		tag_s2 <= tag_s1;
		if (v_s2) begin
			sum_s3   <= sum_c;
			count_s3 <= count_c;
			tag_s3   <= tag_s2;
		end
	end

	assign sum_valid = v_s3;
	assign sum       = sum_s3;
	assign count     = count_s3;
	assign sum_tag   = tag_s3;

endmodule

/* rtl/core/hbs_scale.sv */
// ----------------------------------------------------------------------------
// hbs_scale
// Scales the neighborhood sum and divides it by the neighbor count.
// ----------------------------------------------------------------------------
module hbs_scale import hbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sum_valid,
	input  logic [SUM_W-1:0]   sum,
	input  logic [CNT_W-1:0]   count,
	input  out_tag_t           sum_tag,
	input  logic [SCALE_W-1:0] scale,
	output logic               result_valid,
	output result_t            result
);

	logic                v_s4;
	logic [PROD_W-1:0]   prod_s4;
	recip_t              recip_s4;
	out_tag_t            tag_s4;

	logic                v_s5;
	logic [QUOT_W-1:0]   quot_s5;
	logic [SHIFT_W-1:0]  shift_s5;
	out_tag_t            tag_s5;

	logic                result_valid_q;
	result_t             result_q;

	logic [QUOT_W-1:0]   shifted;

	assign shifted = quot_s5 >> shift_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4           <= 1'b0;
			v_s5           <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			v_s4           <= sum_valid;
			v_s5           <= v_s4;
			result_valid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (sum_valid) begin
			prod_s4  <= PROD_W'(sum) * PROD_W'(scale);
			recip_s4 <= recip_for(count);
			tag_s4   <= sum_tag;
		end
		if (v_s4) begin
			quot_s5  <= QUOT_W'(prod_s4) * QUOT_W'(recip_s4.mult);
			shift_s5 <= recip_s4.shift;
			tag_s5   <= tag_s4;
		end
		if (v_s5) begin
			result_q.height <= shifted[HEIGHT_W-1:0];
			result_q.row    <= tag_s5.row;
			result_q.col    <= tag_s5.col;
			result_q.last   <= tag_s5.last;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

/* rtl/core/heightmap_box_smooth.sv */
// ----------------------------------------------------------------------------
// heightmap_box_smooth
// A result word passes the pipeline registers and the output FIFO after the
// input word that completes its neighborhood (one row and one pixel after
// the center pixel). Throughput: one word per cycle while ready is high, as
// each line store entry is read at acceptance and written back in the next
// cycle. Ready drops while eight result words are pending. Reset clears the
// frame position, window and registers; the line store is not cleared.
// ----------------------------------------------------------------------------
module heightmap_box_smooth import hbs_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wen,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	hbs_pixel_if.sink             pixels,
	hbs_result_if.source          results
);

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int WID_W  = $clog2(MAX_WIDTH + 1);
	localparam int ROW_W  = $clog2(MAX_HEIGHT + 2);
	localparam int ORW_W  = $clog2(MAX_HEIGHT);
	localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);
	localparam int PEND_W = $clog2(OUT_FIFO_DEPTH + 1);

	logic [WIDTH_REG_W-1:0]  image_width_q;
	logic [HEIGHT_REG_W-1:0] image_height_q;
	logic [SCALE_W-1:0]      height_scale_q;

	logic [WID_W-1:0] w_eff;
	logic [HGT_W-1:0] h_eff;

	logic [COL_W-1:0] in_col_q;
	logic [ROW_W-1:0] in_row_q;
	logic [COL_W-1:0] out_col_q;
	logic [ORW_W-1:0] out_row_q;

	logic             accept;
	logic             in_frame;
	logic             go;
	logic             emit;
	logic             row_wrap;
	logic             out_wrap;
	logic             last;
	logic [PIXEL_W-1:0] pix_eff;
	out_tag_t         tag;

	logic             sum_valid;
	logic [SUM_W-1:0] sum;
	logic [CNT_W-1:0] count;
	out_tag_t         sum_tag;

	logic             result_valid;
	result_t          result;

	result_t                fifo_q [OUT_FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]  wr_ptr_q;
	logic [FIFO_PTR_W-1:0]  rd_ptr_q;
	logic [PEND_W-1:0]      fifo_cnt_q;
	logic [PEND_W-1:0]      pending_q;
	logic                   pop;
	logic                   claim;

	always_comb begin
		if (image_width_q == '0) begin
			w_eff = WID_W'(1);
		end else if (32'(image_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = WID_W'(MAX_WIDTH);
		end else begin
			w_eff = WID_W'(image_width_q);
		end
		if (image_height_q == '0) begin
			h_eff = HGT_W'(1);
		end else if (32'(image_height_q) > 32'(MAX_HEIGHT)) begin
			h_eff = HGT_W'(MAX_HEIGHT);
		end else begin
			h_eff = HGT_W'(image_height_q);
		end
	end

	assign pixels.ready = pending_q < PEND_W'(OUT_FIFO_DEPTH);
	assign accept       = pixels.valid && pixels.ready;
	assign in_frame     = 32'(in_row_q) < 32'(h_eff);
	// A flush word inside the frame leaves everything as it is.
	assign go           = accept && !(in_frame && pixels.action);
	assign pix_eff      = in_frame ? pixels.pixel : '0;
	assign emit         = (in_row_q >= ROW_W'(2)) || ((in_row_q == ROW_W'(1)) && (in_col_q != '0));
	assign row_wrap     = (32'(in_col_q) + 32'd1) >= 32'(w_eff);
	assign out_wrap     = (32'(out_col_q) + 32'd1) >= 32'(w_eff);
	assign last         = (32'(out_row_q) + 32'd1 == 32'(h_eff)) && out_wrap;
	assign claim        = go && emit;

	always_comb begin
		tag.emit        = emit;
		tag.mask.left   = out_col_q != '0;
		tag.mask.right  = !out_wrap;
		tag.mask.top    = out_row_q != '0;
		tag.mask.bottom = (32'(out_row_q) + 32'd1) < 32'(h_eff);
		tag.row         = ROW_FIELD_W'(out_row_q);
		tag.col         = COL_FIELD_W'(out_col_q);
		tag.last        = last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RST;
			image_height_q <= IMAGE_HEIGHT_RST;
			height_scale_q <= HEIGHT_SCALE_RST;
			in_col_q       <= '0;
			in_row_q       <= '0;
			out_col_q      <= '0;
			out_row_q      <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					image_width_q <= cfg_wdata[WIDTH_REG_W-1:0];
					in_col_q      <= '0;
					in_row_q      <= '0;
					out_col_q     <= '0;
					out_row_q     <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					image_height_q <= cfg_wdata[HEIGHT_REG_W-1:0];
					in_col_q       <= '0;
					in_row_q       <= '0;
					out_col_q      <= '0;
					out_row_q      <= '0;
				end
				REG_HEIGHT_SCALE: begin
					height_scale_q <= cfg_wdata[SCALE_W-1:0];
				end
				default: begin
				end
			endcase
		end else if (go) begin
			if (emit && last) begin
				in_col_q  <= '0;
				in_row_q  <= '0;
				out_col_q <= '0;
				out_row_q <= '0;
			end else begin
				if (row_wrap) begin
					in_col_q <= '0;
					in_row_q <= in_row_q + ROW_W'(1);
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (emit) begin
					if (out_wrap) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + ORW_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

	hbs_window #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_window (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.col       (in_col_q),
		.pix       (pix_eff),
		.tag       (tag),
		.sum_valid (sum_valid),
		.sum       (sum),
		.count     (count),
		.sum_tag   (sum_tag)
	);

	hbs_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.sum_valid    (sum_valid),
		.sum          (sum),
		.count        (count),
		.sum_tag      (sum_tag),
		.scale        (height_scale_q),
		.result_valid (result_valid),
		.result       (result)
	);

	assign pop = results.valid && results.ready;

	always_ff @(posedge clk) begin
		if (result_valid) begin
			fifo_q[wr_ptr_q] <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q   <= '0;
			rd_ptr_q   <= '0;
			fifo_cnt_q <= '0;
			pending_q  <= '0;
		end else begin
			if (result_valid) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({result_valid, pop})
				2'b10:   fifo_cnt_q <= fifo_cnt_q + PEND_W'(1);
				2'b01:   fifo_cnt_q <= fifo_cnt_q - PEND_W'(1);
				default: fifo_cnt_q <= fifo_cnt_q;
			endcase
			case ({claim, pop})
				2'b10:   pending_q <= pending_q + PEND_W'(1);
				2'b01:   pending_q <= pending_q - PEND_W'(1);
				default: pending_q <= pending_q;
			endcase
		end
	end

	assign results.valid      = fifo_cnt_q != '0;
	assign results.height     = fifo_q[rd_ptr_q].height;
	assign results.out_row    = fifo_q[rd_ptr_q].row;
	assign results.out_col    = fifo_q[rd_ptr_q].col;
	assign results.frame_last = fifo_q[rd_ptr_q].last;

endmodule

/* sim/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for heightmap_box_smooth. Pixel and flush words stream
// in through the valid/ready channel while a cycle-free predictor of the 3x3
// border-aware mean tracks frame position, line stores and window. Each
// result word is compared field by field with the oldest prediction.
// Directed frames cover the reset width, tiny images, every neighbor count
// and out-of-range geometry values. Random frames follow with random geometry,
// scale and content, stray flushes, early aborts and changing idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
	import hbs_pkg::*;

	localparam bit ACT_PIXEL = 1'b0;
	localparam bit ACT_FLUSH = 1'b1;
	localparam int LS_DEPTH = DEF_MAX_WIDTH;
	localparam int unsigned RANDOM_WORDS = 800;
	localparam int unsigned NO_LIMIT = 32'hFFFF_FFFF;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	hbs_pixel_if  pix_if();
	hbs_result_if res_if();

	heightmap_box_smooth DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wen  (cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.pixels   (pix_if),
		.results  (res_if)
	);

	logic [PIXEL_W-1:0]      row_above [LS_DEPTH];
	logic [PIXEL_W-1:0]      row_above2 [LS_DEPTH];
	logic [PIXEL_W-1:0]      win [3][3];
	int unsigned             in_row_pos;
	int unsigned             in_col_pos;
	int unsigned             out_pos;
	logic [WIDTH_REG_W-1:0]  reg_width;
	logic [HEIGHT_REG_W-1:0] reg_height;
	logic [SCALE_W-1:0]      reg_scale;

	result_t     pending_heights[$];
	int unsigned words_taken = 0;
	int unsigned words_ignored = 0;
	int unsigned results_checked = 0;
	int unsigned frames_predicted = 0;
	int unsigned mismatches = 0;
	int unsigned src_idle_pct = 0;
	int unsigned snk_idle_pct = 0;

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic int unsigned eff_width();
		if (reg_width == 0) return 1;
		if (reg_width > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return 32'(reg_width);
	endfunction

	function automatic int unsigned eff_height();
		if (reg_height == 0) return 1;
		if (reg_height > DEF_MAX_HEIGHT) return DEF_MAX_HEIGHT;
		return 32'(reg_height);
	endfunction

	function automatic void restart_frame();
		in_row_pos = 0;
		in_col_pos = 0;
		out_pos = 0;
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_IMAGE_WIDTH: begin
				reg_width = data[WIDTH_REG_W-1:0];
				restart_frame();
			end
			REG_IMAGE_HEIGHT: begin
				reg_height = data[HEIGHT_REG_W-1:0];
				restart_frame();
			end
			REG_HEIGHT_SCALE: begin
				reg_scale = data[SCALE_W-1:0];
			end
			default: begin
			end
		endcase
	endfunction

	// Returns 0 when the word is ignored; emit tells whether a result follows.
	function automatic bit smooth_predict(input bit act, input logic [PIXEL_W-1:0] pix,
		output bit emit, output result_t r);
		int unsigned w, h, c, n, orow, ocol, sum, cnt;
		longint unsigned scaled;
		logic [PIXEL_W-1:0] sample;
		w = eff_width();
		h = eff_height();
		emit = 1'b0;
		r = '0;
		sample = pix;
		if (in_row_pos < h) begin
			if (act == ACT_FLUSH) return 1'b0;
		end else begin
			sample = '0;
		end
		c = in_col_pos;
		for (int i = 0; i < 3; i++) begin
			win[0][i] = win[1][i];
			win[1][i] = win[2][i];
		end
		win[2][0] = row_above2[c];
		win[2][1] = row_above[c];
		win[2][2] = sample;
		row_above2[c] = row_above[c];
		row_above[c] = sample;
		n = in_row_pos * w + in_col_pos;
		in_col_pos++;
		if (in_col_pos >= w) begin
			in_col_pos = 0;
			in_row_pos++;
		end
		if (n < w + 1) return 1'b1;
		orow = out_pos / w;
		ocol = out_pos % w;
		sum = 0;
		cnt = 0;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (!((i == 0 && ocol == 0) || (i == 2 && ocol + 1 >= w) ||
					(j == 0 && orow == 0) || (j == 2 && orow + 1 >= h))) begin
					sum += 32'(win[i][j]);
					cnt++;
				end
			end
		end
		if (cnt == 0) cnt = 1;
		scaled = longint'(sum) * longint'(reg_scale);
		scaled = scaled / cnt;
		r.height = scaled[HEIGHT_W-1:0];
		r.row = orow[ROW_FIELD_W-1:0];
		r.col = ocol[COL_FIELD_W-1:0];
		r.last = (out_pos == w * h - 1);
		out_pos++;
		if (r.last) begin
			restart_frame();
			frames_predicted++;
		end
		emit = 1'b1;
		return 1'b1;
	endfunction

	function automatic logic [PIXEL_W-1:0] random_pixel();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic void check_field(input string field, input int unsigned want,
		input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatches++;
		end
	endfunction

	task automatic set_idle(input int unsigned src, input int unsigned snk);
		src_idle_pct = src;
		snk_idle_pct = snk;
	endtask

	task automatic send_word(input bit act, input logic [PIXEL_W-1:0] pix);
		result_t r;
		bit emit;
		while ($urandom_range(99) < src_idle_pct) begin
			pix_if.valid <= 1'b0;
			@(posedge clk);
		end
		pix_if.valid <= 1'b1;
		pix_if.action <= act;
		pix_if.pixel <= pix;
		do @(posedge clk); while (!pix_if.ready);
		if (smooth_predict(act, pix, emit, r)) words_taken++;
		else words_ignored++;
		if (emit) pending_heights.push_back(r);
	endtask

	task automatic settle();
		pix_if.valid <= 1'b0;
		while (pending_heights.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		settle();
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_wen <= 1'b0;
		apply_reg(idx, data);
	endtask

	// Sends up to pixel_limit pixels; a complete frame is followed by its drain words.
	task automatic run_frame(input int unsigned pixel_limit, input int unsigned noise_pct);
		int unsigned total, fw;
		fw = eff_width();
		total = fw * eff_height();
		for (int unsigned k = 0; k < total && k < pixel_limit; k++) begin
			if ($urandom_range(99) < noise_pct) send_word(ACT_FLUSH, random_pixel());
			send_word(ACT_PIXEL, random_pixel());
		end
		if (pixel_limit < total) return;
		for (int unsigned k = 0; k < fw + 1; k++) begin
			if ($urandom_range(1) == 0) send_word(ACT_FLUSH, random_pixel());
			else send_word(ACT_PIXEL, random_pixel());
		end
	endtask

	task automatic test_reset_values();
		set_idle(21, 87);
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		run_frame(NO_LIMIT, 0);
	endtask

	task automatic test_small_images();
		logic [PIXEL_W-1:0] grid [9];
		grid = '{8'hFF, 8'h00, 8'hAA, 8'h55, 8'hFF, 8'h01, 8'h80, 8'hFE, 8'h7F};
		set_idle(21, 87);
		write_reg(REG_HEIGHT_SCALE, 16'hFFFF);
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		send_word(ACT_PIXEL, 8'hFF);
		send_word(ACT_PIXEL, 8'h55);
		send_word(ACT_FLUSH, 8'h00);
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd3);
		for (int k = 0; k < 9; k++) begin
			if (k == 4) send_word(ACT_FLUSH, 8'hFF);
			send_word(ACT_PIXEL, grid[k]);
		end
		repeat (4) send_word(ACT_FLUSH, 8'h00);
		write_reg(REG_HEIGHT_SCALE, 16'h0101);
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		send_word(ACT_PIXEL, 8'hFF);
		send_word(ACT_PIXEL, 8'hFF);
		send_word(ACT_PIXEL, 8'h00);
		repeat (2) send_word(ACT_FLUSH, 8'h00);
		write_reg(REG_IMAGE_WIDTH, 16'd3);
		write_reg(REG_IMAGE_HEIGHT, 16'd1);
		send_word(ACT_PIXEL, 8'h10);
		send_word(ACT_PIXEL, 8'hEF);
		send_word(ACT_PIXEL, 8'h33);
		repeat (4) send_word(ACT_FLUSH, 8'h00);
	endtask

	task automatic test_geometry_extremes();
		set_idle(87, 21);
		write_reg(REG_HEIGHT_SCALE, 16'd0);
		write_reg(REG_IMAGE_WIDTH, 16'd0);
		write_reg(REG_IMAGE_HEIGHT, 16'd0);
		run_frame(NO_LIMIT, 0);
		set_idle(0, 0);
		write_reg(REG_HEIGHT_SCALE, 16'hFFFF);
		write_reg(REG_IMAGE_WIDTH, 16'd1);
		write_reg(REG_IMAGE_HEIGHT, 16'd8191);
		run_frame(40, 0);
	endtask

	task automatic test_random_frames();
		int unsigned start, total;
		logic [CFG_DATA_W-1:0] w, h, s;
		bit new_geom;
		start = words_taken;
		new_geom = 1'b1;
		while (words_taken - start < RANDOM_WORDS) begin
			if (words_taken - start < RANDOM_WORDS / 3) set_idle(21, 87);
			else if (words_taken - start < 2 * RANDOM_WORDS / 3) set_idle(87, 21);
			else set_idle(0, 0);
			if (new_geom || $urandom_range(2) == 0) begin
				case ($urandom_range(9))
					0: w = 16'd0;
					1: w = 16'd1;
					2: w = 16'($urandom_range(15, 48));
					default: w = 16'($urandom_range(2, 14));
				endcase
				case ($urandom_range(7))
					0: h = 16'd0;
					1: h = 16'd1;
					default: h = 16'($urandom_range(2, 6));
				endcase
				write_reg(REG_IMAGE_WIDTH, w);
				write_reg(REG_IMAGE_HEIGHT, h);
				new_geom = 1'b0;
			end
			if ($urandom_range(2) == 0) begin
				case ($urandom_range(3))
					0: s = 16'd0;
					1: s = 16'hFFFF;
					default: s = 16'($urandom);
				endcase
				write_reg(REG_HEIGHT_SCALE, s);
			end
			total = eff_width() * eff_height();
			if ($urandom_range(11) == 0) begin
				run_frame($urandom_range(total - 1), 5);
				new_geom = 1'b1;
			end else begin
				run_frame(NO_LIMIT, 5);
			end
		end
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (!arst_n) begin
			res_if.ready <= 1'b0;
		end else begin
			if (res_if.valid && res_if.ready) begin
				if (pending_heights.size() == 0) begin
					$display("%0t: unexpected result word, expected none, actual height %0d row %0d col %0d",
						$time, res_if.height, res_if.out_row, res_if.out_col);
					mismatches++;
				end else begin
					want = pending_heights.pop_front();
					check_field("height", 32'(want.height), 32'(res_if.height));
					check_field("out_row", 32'(want.row), 32'(res_if.out_row));
					check_field("out_col", 32'(want.col), 32'(res_if.out_col));
					check_field("frame_last", 32'(want.last), 32'(res_if.frame_last));
					results_checked++;
				end
			end
			res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	initial begin
		#20_000_000;
		$display("[heightmap_box_smooth] ERROR");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_IMAGE_WIDTH;
		cfg_wdata = '0;
		pix_if.valid = 1'b0;
		pix_if.action = ACT_PIXEL;
		pix_if.pixel = '0;
		for (int k = 0; k < LS_DEPTH; k++) begin
			row_above[k] = '0;
			row_above2[k] = '0;
		end
		win = '{default: '0};
		reg_width = IMAGE_WIDTH_RST;
		reg_height = IMAGE_HEIGHT_RST;
		reg_scale = HEIGHT_SCALE_RST;
		restart_frame();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_small_images();
		test_geometry_extremes();
		test_random_frames();
		settle();
		repeat (10) @(posedge clk);
		$display("Run covered %0d frames and %0d result words from %0d pixel and flush words",
			frames_predicted, results_checked, words_taken);
		$display("(%0d stray flush words ignored), with clamped, tiny and random image sizes.",
			words_ignored);
		if (mismatches == 0) begin
			$display("[heightmap_box_smooth] OK");
		end else begin
			$display("[heightmap_box_smooth] ERROR");
		end
		$finish;
	end

endmodule

/* files.f */
rtl/core/hbs_pkg.sv
rtl/core/hbs_stream_if.sv
rtl/core/hbs_window.sv
rtl/core/hbs_scale.sv
rtl/core/heightmap_box_smooth.sv
sim/tb_top.sv
